>>> rtl/core/bpa_pkg.sv
// Shared types and constants of the buddy page allocator.
package bpa_pkg;

    localparam int COUNT_W = 11;
    localparam int PAGE_W  = 10;
    localparam int START_W = 10;
    localparam int STAT_W  = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_A_ROOT,
        S_A_DESC,
        S_A_MARK,
        S_F_FIND,
        S_UP,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_A_ROOT,
        OP_A_DESC,
        OP_A_MARK,
        OP_F_FIND,
        OP_UP,
        OP_DONE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic req_bad;
        logic root_short;
        logic root_exact;
        logic desc_done;
        logic node_top;
        logic find_used;
        logic misaligned;
        logic up_top;
        logic out_busy;
    } t_dp_stat;

endpackage

>>> rtl/core/bpa_datapath.sv
// Tree memory, walk registers and result register of the buddy page allocator.
module bpa_datapath #(
    parameter int NUM_PAGES = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpa_pkg::t_dp_cmd              i_cmd,
    output bpa_pkg::t_dp_stat             o_stat,
    input  logic                          i_mode,
    input  logic [bpa_pkg::COUNT_W-1:0]   i_count,
    input  logic [bpa_pkg::PAGE_W-1:0]    i_page,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output bpa_pkg::t_status              o_status,
    output logic [bpa_pkg::START_W-1:0]   o_start
);

    localparam int LEVELS = $clog2(NUM_PAGES);
    localparam int LW     = (LEVELS < 1) ? 1 : LEVELS;
    localparam int VW     = LEVELS + 1;
    localparam int AW     = LEVELS + 1;
    localparam int NODES  = 2 * NUM_PAGES - 1;
    localparam int SW     = bpa_pkg::START_W;
    localparam int CW     = bpa_pkg::COUNT_W;

    logic [VW-1:0] r_mem [NODES];
    logic [VW-1:0] r_rd_data;

    logic [AW-1:0] r_clr_idx, n_clr_idx;
    logic [VW-1:0] r_clr_size, n_clr_size;
    logic          r_out_valid, n_out_valid;

    logic                          r_mode, n_mode;
    logic [bpa_pkg::PAGE_W-1:0]    r_page, n_page;
    logic [VW-1:0]                 r_want, n_want;
    logic                          r_req_bad, n_req_bad;
    logic [AW-1:0]                 r_node, n_node;
    logic [VW-1:0]                 r_size, n_size;
    logic [LW-1:0]                 r_start, n_start;
    logic [VW-1:0]                 r_cur, n_cur;
    bpa_pkg::t_status              r_res_status, n_res_status;
    logic [LW-1:0]                 r_res_start, n_res_start;
    bpa_pkg::t_status              r_out_status, n_out_status;
    logic [LW-1:0]                 r_out_start, n_out_start;

    logic          we;
    logic [AW-1:0] wa;
    logic [VW-1:0] wd;
    logic [AW-1:0] ra;

    logic [AW:0]   clr_idx1;
    logic [CW-1:0] cnt_m1;
    logic [CW:0]   want_full;
    logic [AW-1:0] left_node, pick_node, parent_node, par_sib, node_sib;
    logic [VW-1:0] half_size, up_val;
    logic          go_left, bad_in, misalign, par_top;

    always_comb begin
        clr_idx1 = {1'b0, r_clr_idx} + 1'b1;

        cnt_m1 = i_count - 1'b1;
        cnt_m1 = cnt_m1 | (cnt_m1 >> 1);
        cnt_m1 = cnt_m1 | (cnt_m1 >> 2);
        cnt_m1 = cnt_m1 | (cnt_m1 >> 4);
        cnt_m1 = cnt_m1 | (cnt_m1 >> 8);
        want_full = {1'b0, cnt_m1} + 1'b1;

        if (i_mode) begin
            bad_in = 32'(i_page) >= 32'(NUM_PAGES);
        end else begin
            bad_in = (i_count == '0) || (32'(i_count) > 32'(NUM_PAGES));
        end

        left_node   = {r_node[AW-2:0], 1'b1};
        go_left     = r_rd_data >= r_want;
        pick_node   = go_left ? left_node : left_node + 1'b1;
        half_size   = r_size >> 1;
        parent_node = (r_node - 1'b1) >> 1;
        par_top     = parent_node == '0;
        par_sib     = parent_node[0] ? parent_node + 1'b1 : parent_node - 1'b1;
        node_sib    = r_node[0] ? r_node + 1'b1 : r_node - 1'b1;
        misalign    = (32'(r_page) & (32'(r_size) - 32'd1)) != 32'd0;

        if ((r_cur == r_size) && (r_rd_data == r_size)) begin
            up_val = r_size << 1;
        end else begin
            up_val = (r_cur > r_rd_data) ? r_cur : r_rd_data;
        end
    end

    always_comb begin
        n_clr_idx    = r_clr_idx;
        n_clr_size   = r_clr_size;
        n_mode       = r_mode;
        n_page       = r_page;
        n_want       = r_want;
        n_req_bad    = r_req_bad;
        n_node       = r_node;
        n_size       = r_size;
        n_start      = r_start;
        n_cur        = r_cur;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_out_status = r_out_status;
        n_out_start  = r_out_start;
        n_out_valid  = r_out_valid && !i_m_tready;
        we = 1'b0;
        wa = '0;
        wd = '0;
        ra = '0;

        case (i_cmd.op)
            bpa_pkg::OP_CLEAR: begin
                we = 1'b1;
                wa = r_clr_idx;
                wd = r_clr_size;
                n_clr_idx = clr_idx1[AW-1:0];
                if (((clr_idx1 + 1'b1) & clr_idx1) == '0) begin
                    n_clr_size = r_clr_size >> 1;
                end
            end
            bpa_pkg::OP_LOAD: begin
                n_mode       = i_mode;
                n_page       = i_page;
                n_want       = VW'(want_full);
                n_req_bad    = bad_in;
                n_node       = i_mode ? AW'(32'(i_page) + 32'(NUM_PAGES) - 32'd1) : '0;
                n_size       = i_mode ? VW'(1) : VW'(NUM_PAGES);
                n_start      = '0;
                n_res_start  = '0;
                n_res_status = bpa_pkg::ST_OK;
                if (i_mode && !bad_in) begin
                    ra = AW'(32'(i_page) + 32'(NUM_PAGES) - 32'd1);
                end
            end
            bpa_pkg::OP_A_ROOT: begin
                if (r_req_bad) begin
                    n_res_status = bpa_pkg::ST_BAD;
                end else if (r_want > r_rd_data) begin
                    n_res_status = bpa_pkg::ST_FULL;
                end else begin
                    ra = left_node;
                end
            end
            bpa_pkg::OP_A_DESC: begin
                n_node = pick_node;
                n_size = half_size;
                if (!go_left) begin
                    n_start = r_start + LW'(half_size);
                end
                if (half_size != r_want) begin
                    ra = {pick_node[AW-2:0], 1'b1};
                end
            end
            bpa_pkg::OP_A_MARK: begin
                we = 1'b1;
                wa = r_node;
                wd = '0;
                n_cur = '0;
                n_res_start = r_start;
                if (r_node != '0) begin
                    ra = node_sib;
                end
            end
            bpa_pkg::OP_F_FIND: begin
                if (r_req_bad) begin
                    n_res_status = bpa_pkg::ST_BAD;
                end else if (r_rd_data != '0) begin
                    if (r_node == '0) begin
                        n_res_status = bpa_pkg::ST_BAD;
                    end else begin
                        n_node = parent_node;
                        n_size = r_size << 1;
                        ra = parent_node;
                    end
                end else if (misalign) begin
                    n_res_status = bpa_pkg::ST_BAD;
                end else begin
                    we = 1'b1;
                    wa = r_node;
                    wd = r_size;
                    n_cur = r_size;
                    if (r_node != '0) begin
                        ra = node_sib;
                    end
                end
            end
            bpa_pkg::OP_UP: begin
                we = 1'b1;
                wa = parent_node;
                wd = up_val;
                n_cur  = up_val;
                n_node = parent_node;
                n_size = r_size << 1;
                if (!par_top) begin
                    ra = par_sib;
                end
            end
            bpa_pkg::OP_DONE: begin
                if (!(r_out_valid && !i_m_tready)) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_start  = r_res_start;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd_data <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_clr_size  <= VW'(NUM_PAGES);
            r_out_valid <= 1'b0;
        end else begin
            r_clr_idx   <= n_clr_idx;
            r_clr_size  <= n_clr_size;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_page       <= n_page;
        r_want       <= n_want;
        r_req_bad    <= n_req_bad;
        r_node       <= n_node;
        r_size       <= n_size;
        r_start      <= n_start;
        r_cur        <= n_cur;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_out_status <= n_out_status;
        r_out_start  <= n_out_start;
    end

    always_comb begin
        o_stat.clr_last   = 32'(r_clr_idx) == 32'(NODES - 1);
        o_stat.req_bad    = r_req_bad;
        o_stat.root_short = r_want > r_rd_data;
        o_stat.root_exact = r_size == r_want;
        o_stat.desc_done  = half_size == r_want;
        o_stat.node_top   = r_node == '0;
        o_stat.find_used  = r_rd_data == '0;
        o_stat.misaligned = misalign || r_mode == 1'b0;
        o_stat.up_top     = par_top;
        o_stat.out_busy   = r_out_valid && !i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_status   = r_out_status;
    assign o_start    = SW'(r_out_start);

endmodule

>>> rtl/core/bpa_controller.sv
// Request sequencer of the buddy page allocator.
module bpa_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_mode,
    output logic              o_s_tready,
    input  bpa_pkg::t_dp_stat i_stat,
    output bpa_pkg::t_dp_cmd  o_cmd
);

    bpa_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = bpa_pkg::OP_NONE;
        o_s_tready = 1'b0;
        case (r_state)
            bpa_pkg::S_CLEAR: begin
                o_cmd.op = bpa_pkg::OP_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = bpa_pkg::OP_LOAD;
                    n_state  = i_mode ? bpa_pkg::S_F_FIND : bpa_pkg::S_A_ROOT;
                end
            end
            bpa_pkg::S_A_ROOT: begin
                o_cmd.op = bpa_pkg::OP_A_ROOT;
                if (i_stat.req_bad || i_stat.root_short) begin
                    n_state = bpa_pkg::S_DONE;
                end else if (i_stat.root_exact) begin
                    n_state = bpa_pkg::S_A_MARK;
                end else begin
                    n_state = bpa_pkg::S_A_DESC;
                end
            end
            bpa_pkg::S_A_DESC: begin
                o_cmd.op = bpa_pkg::OP_A_DESC;
                if (i_stat.desc_done) begin
                    n_state = bpa_pkg::S_A_MARK;
                end
            end
            bpa_pkg::S_A_MARK: begin
                o_cmd.op = bpa_pkg::OP_A_MARK;
                n_state  = i_stat.node_top ? bpa_pkg::S_DONE : bpa_pkg::S_UP;
            end
            bpa_pkg::S_F_FIND: begin
                o_cmd.op = bpa_pkg::OP_F_FIND;
                if (i_stat.req_bad) begin
                    n_state = bpa_pkg::S_DONE;
                end else if (!i_stat.find_used) begin
                    if (i_stat.node_top) begin
                        n_state = bpa_pkg::S_DONE;
                    end
                end else if (i_stat.misaligned || i_stat.node_top) begin
                    n_state = bpa_pkg::S_DONE;
                end else begin
                    n_state = bpa_pkg::S_UP;
                end
            end
            bpa_pkg::S_UP: begin
                o_cmd.op = bpa_pkg::OP_UP;
                if (i_stat.up_top) begin
                    n_state = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_DONE: begin
                o_cmd.op = bpa_pkg::OP_DONE;
                if (!i_stat.out_busy) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bpa_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

>>> rtl/core/buddy_page_allocator_core.sv
// Top level of the binary buddy page allocator.
//
// Requests enter on the s_axis channel, one item at a time; tuser[0] selects
// allocate (0) or free (1). Each request yields exactly one result item on
// m_axis: tuser holds the status, tdata the first page of a granted block.
// An allocate descends the tree one level per cycle to a block of size pages,
// then rebuilds maxima one level per cycle up to the root; a free climbs to
// the used node, then merges up to the root; a bad count, a page out of range
// or an allocate with no room goes straight to the result.
// The next request is accepted in the cycle after the result is loaded, so
// each request holds the block until its result is loaded.
// The walk is bound by the single-write, single-read tree memory: one level
// per cycle in each direction.
// After reset the tree memory is swept to all free, one node per cycle, over
// all 2*NUM_PAGES-1 nodes; s_axis_tready stays low during the sweep.
// The result sits in an output register: a new request is accepted while it
// waits, and a stalled receiver holds the block only when the next result is
// ready to be written.
module buddy_page_allocator_core #(
    parameter int NUM_PAGES = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: page_count[10:0], page_index[20:11], zero pad
    input  logic [bpa_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // tuser: mode[0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: start_page[9:0], zero pad
    output logic [bpa_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // tuser: status[1:0]
    output logic [bpa_pkg::STAT_W-1:0]     m_axis_tuser
);

    localparam int CW = bpa_pkg::COUNT_W;
    localparam int PW = bpa_pkg::PAGE_W;
    localparam int SW = bpa_pkg::START_W;
    localparam int MW = bpa_pkg::M_DATA_W;

    bpa_pkg::t_dp_cmd  cmd;
    bpa_pkg::t_dp_stat stat;
    bpa_pkg::t_status  out_status;
    logic [SW-1:0]     out_start;

    bpa_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_mode     (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bpa_datapath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_mode     (s_axis_tuser),
        .i_count    (s_axis_tdata[CW-1:0]),
        .i_page     (s_axis_tdata[CW+PW-1:CW]),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_status   (out_status),
        .o_start    (out_start)
    );

    assign m_axis_tdata = MW'(out_start);
    assign m_axis_tuser = out_status;

endmodule

>>> rtl/core/bpa_checker.sv
// Port-level checks of the buddy page allocator, bound to the top level.
module bpa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [bpa_pkg::S_DATA_W-1:0] s_axis_tdata,
    input logic                         s_axis_tuser,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [bpa_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic [bpa_pkg::STAT_W-1:0]   m_axis_tuser
);

    a_sweep_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request accepted during tree sweep");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == bpa_pkg::ST_OK) ||
                          (m_axis_tuser == bpa_pkg::ST_FULL) ||
                          (m_axis_tuser == bpa_pkg::ST_BAD))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != bpa_pkg::ST_OK) |-> m_axis_tdata == '0)
        else $error("start page set on failed request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (.*);

>>> tb/bpa_grant_checker.sv
`timescale 1ns / 100ps
// Grant checker of the buddy page allocator: free-tree predictor and result compare.
module bpa_grant_checker
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    // tdata: page_count[10:0], page_index[20:11], zero pad
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // tuser: mode[0]
    input  logic                i_s_tuser,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    // tdata: start_page[9:0], zero pad
    input  logic [M_DATA_W-1:0] i_m_tdata,
    // tuser: status[1:0]
    input  logic [STAT_W-1:0]   i_m_tuser,
    output int                  o_fail_count
);

    localparam int TREE_N = 2 * NUM_PAGES - 1;

    typedef struct packed {
        t_status             status;
        logic [START_W-1:0]  start_page;
    } t_grant;

    logic [COUNT_W-1:0] free_tree [TREE_N];
    t_grant             grant_q [$];
    t_grant             exp_grant;
    int                 mismatches = 0;

    function automatic t_grant tree_alloc(input int unsigned count);
        t_grant      g;
        int unsigned want;
        int unsigned node;
        int unsigned nsize;
        int unsigned l;
        int unsigned r;
        g.status     = ST_BAD;
        g.start_page = '0;
        node         = 0;
        nsize        = NUM_PAGES;
        want         = 1;
        if (count == 0 || count > NUM_PAGES) begin
            return g;
        end
        while (want < count) want <<= 1;
        if (want > free_tree[0]) begin
            g.status = ST_FULL;
            return g;
        end
        while (nsize > want) begin
            if (free_tree[2 * node + 1] >= want) begin
                node = 2 * node + 1;
            end else begin
                node = 2 * node + 2;
            end
            nsize >>= 1;
        end
        free_tree[node] = '0;
        g.status        = ST_OK;
        g.start_page    = START_W'((node + 1) * nsize - NUM_PAGES);
        while (node != 0) begin
            node            = (node - 1) >> 1;
            l               = free_tree[2 * node + 1];
            r               = free_tree[2 * node + 2];
            free_tree[node] = COUNT_W'((l > r) ? l : r);
        end
        return g;
    endfunction

    function automatic t_grant tree_free(input int unsigned page);
        t_grant      g;
        int unsigned node;
        int unsigned bsize;
        int unsigned l;
        int unsigned r;
        g.status     = ST_BAD;
        g.start_page = '0;
        if (page >= NUM_PAGES) begin
            return g;
        end
        node  = page + NUM_PAGES - 1;
        bsize = 1;
        while (free_tree[node] != 0) begin
            if (node == 0) begin
                return g;
            end
            node  = (node - 1) >> 1;
            bsize <<= 1;
        end
        if ((node + 1) * bsize - NUM_PAGES != page) begin
            return g;
        end
        free_tree[node] = COUNT_W'(bsize);
        while (node != 0) begin
            node = (node - 1) >> 1;
            l    = free_tree[2 * node + 1];
            r    = free_tree[2 * node + 2];
            if (l == bsize && r == bsize) begin
                free_tree[node] = COUNT_W'(2 * bsize);
            end else begin
                free_tree[node] = COUNT_W'((l > r) ? l : r);
            end
            bsize <<= 1;
        end
        g.status = ST_OK;
        return g;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TREE_N; i++) begin
                free_tree[i] = COUNT_W'(NUM_PAGES >> ($clog2(i + 2) - 1));
            end
            grant_q.delete();
            mismatches = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser) begin
                    grant_q.push_back(tree_free(i_s_tdata[COUNT_W +: PAGE_W]));
                end else begin
                    grant_q.push_back(tree_alloc(i_s_tdata[COUNT_W-1:0]));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (grant_q.size() == 0) begin
                    $error("result item with no request pending: status %0d, start_page %0d",
                           i_m_tuser, i_m_tdata[START_W-1:0]);
                    mismatches++;
                end else begin
                    exp_grant = grant_q.pop_front();
                    if (i_m_tuser != exp_grant.status) begin
                        $error("status: expected %0d, got %0d", exp_grant.status, i_m_tuser);
                        mismatches++;
                    end
                    if (i_m_tdata[START_W-1:0] != exp_grant.start_page) begin
                        $error("start_page: expected %0d, got %0d",
                               exp_grant.start_page, i_m_tdata[START_W-1:0]);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count = mismatches + grant_q.size();
    end

endmodule

>>> tb/buddy_page_allocator_core_tb.sv
`timescale 1ns / 100ps
// Testbench top of the buddy page allocator: request stimulus and verdict.
module buddy_page_allocator_core_tb;
    import bpa_pkg::*;

    localparam int   NUM_PAGES   = 1024;
    localparam logic MODE_ALLOC  = 1'b0;
    localparam logic MODE_FREE   = 1'b1;
    localparam int   NUM_PHASES  = 7;
    localparam int   PHASE_ITEMS = 60;

    typedef struct {
        logic        is_alloc;
        int unsigned size;
    } t_sent;

    typedef struct {
        logic [PAGE_W-1:0] start;
        int unsigned       size;
    } t_block;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]   m_axis_tuser;
    int                  fail_count;

    t_sent       pending_req_q [$];
    t_block      held_blocks [$];
    t_sent       done_req;
    int unsigned tx_gap_max = 5;
    int unsigned rx_gap_max = 5;
    int unsigned rx_stall   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    buddy_page_allocator_core #(
        .NUM_PAGES(NUM_PAGES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bpa_grant_checker #(
        .NUM_PAGES(NUM_PAGES)
    ) u_grant_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count)
    );

    // hold off the result channel for a random count after every item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_stall = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                rx_stall = $urandom_range(0, rx_gap_max);
            end else if (rx_stall != 0) begin
                rx_stall = rx_stall - 1;
            end
            m_axis_tready <= (rx_stall == 0);
        end
    end

    // track granted blocks so that frees can target them
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready && pending_req_q.size() != 0) begin
            done_req = pending_req_q.pop_front();
            if (done_req.is_alloc && m_axis_tuser == ST_OK) begin
                held_blocks.push_back('{m_axis_tdata[PAGE_W-1:0], done_req.size});
            end
        end
    end

    task automatic send_request(input logic mode, input logic [COUNT_W-1:0] count,
                                input logic [PAGE_W-1:0] page);
        int unsigned gap;
        int unsigned size;
        t_sent       rec;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W - COUNT_W - PAGE_W){1'b0}}, page, count};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        size = 1;
        while (size < count) size <<= 1;
        rec.is_alloc = (mode == MODE_ALLOC);
        rec.size     = size;
        pending_req_q.push_back(rec);
    endtask

    initial begin : stimulus
        int unsigned          r;
        int unsigned          k;
        int unsigned          alloc_pct;
        logic [COUNT_W-1:0]   count;
        logic [PAGE_W-1:0]    page;
        t_block               blk;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(MODE_ALLOC, 11'd0,    10'd0);
        send_request(MODE_ALLOC, 11'd2047, 10'd1023);
        send_request(MODE_ALLOC, 11'd1025, 10'd0);
        send_request(MODE_ALLOC, 11'd1024, 10'd0);
        send_request(MODE_ALLOC, 11'd1,    10'd0);
        send_request(MODE_FREE,  11'd0,    10'd5);
        send_request(MODE_FREE,  11'd2047, 10'd1023);
        send_request(MODE_FREE,  11'd0,    10'd0);
        send_request(MODE_FREE,  11'd0,    10'd0);
        send_request(MODE_ALLOC, 11'd1,    10'd1023);
        send_request(MODE_ALLOC, 11'd3,    10'd0);
        send_request(MODE_ALLOC, 11'd2,    10'd0);
        send_request(MODE_ALLOC, 11'd512,  10'd0);
        send_request(MODE_ALLOC, 11'd256,  10'd0);
        send_request(MODE_ALLOC, 11'd129,  10'd0);
        send_request(MODE_ALLOC, 11'd128,  10'd0);
        send_request(MODE_FREE,  11'd0,    10'd1);
        send_request(MODE_FREE,  11'd0,    10'd6);
        send_request(MODE_FREE,  11'd0,    10'd512);
        send_request(MODE_FREE,  11'd0,    10'd4);
        send_request(MODE_ALLOC, 11'd1,    10'd0);
        send_request(MODE_FREE,  11'd1024, 10'd1023);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case ($urandom_range(0, 2))
                0:       alloc_pct = 80;
                1:       alloc_pct = 50;
                default: alloc_pct = 25;
            endcase
            tx_gap_max = (phase == 0 || $urandom_range(0, 3) == 0) ? 0 : 5;
            rx_gap_max = (phase == 0 || $urandom_range(0, 3) == 0) ? 0 : 5;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                count = COUNT_W'($urandom_range(0, 2047));
                page  = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
                if (held_blocks.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
                    r = $urandom_range(0, 99);
                    if (r < 3) begin
                        count = '0;
                    end else if (r < 6) begin
                        count = COUNT_W'($urandom_range(NUM_PAGES + 1, 2047));
                    end else if (r < 10) begin
                        count = COUNT_W'($urandom_range(257, NUM_PAGES));
                    end else if (r < 25) begin
                        count = COUNT_W'($urandom_range(17, 256));
                    end else begin
                        count = COUNT_W'($urandom_range(1, 16));
                    end
                    send_request(MODE_ALLOC, count, page);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 85 && held_blocks.size() != 0) begin
                        k   = $urandom_range(0, held_blocks.size() - 1);
                        blk = held_blocks[k];
                        if (r < 70) begin
                            page = blk.start;
                            held_blocks.delete(k);
                        end else if (blk.size > 1) begin
                            page = PAGE_W'(blk.start + $urandom_range(1, blk.size - 1));
                        end else begin
                            page = blk.start;
                        end
                    end
                    send_request(MODE_FREE, count, page);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_req_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("buddy_page_allocator_core regression: pass");
        end else begin
            $display("buddy_page_allocator_core regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("buddy_page_allocator_core regression: fail");
        $finish;
    end

endmodule
